// ===== rtl/ptu_pkg.sv =====
// Shared constants, codes and control types of the page table unit.
package ptu_pkg;

   localparam int DIR_ENTRIES     = 1024;
   localparam int DIR_AW          = 10;
   localparam int DIR_CW          = DIR_AW + 1;
   localparam int PAGES_PER_TABLE = 1024;
   localparam int PAGE_W          = 10;
   localparam int OFFSET_W        = 12;
   localparam int VA_W            = 32;
   localparam int PA_W            = 32;
   localparam int FRAME_W         = 20;
   localparam int TE_W            = FRAME_W + 1;
   localparam int CMD_W           = 2;
   localparam int STATUS_W        = 3;

   localparam logic [CMD_W-1:0] CMD_TRANSLATE = 2'd0;
   localparam logic [CMD_W-1:0] CMD_MAP       = 2'd1;
   localparam logic [CMD_W-1:0] CMD_UNMAP     = 2'd2;

   localparam logic [STATUS_W-1:0] STATUS_OK      = 3'd0;
   localparam logic [STATUS_W-1:0] STATUS_ABSENT  = 3'd1;
   localparam logic [STATUS_W-1:0] STATUS_LARGE   = 3'd2;
   localparam logic [STATUS_W-1:0] STATUS_MAPPED  = 3'd3;
   localparam logic [STATUS_W-1:0] STATUS_NO_SLOT = 3'd4;

   typedef enum logic [1:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_DIR,
      ST_TAB
   } state_type;

   typedef struct packed {
      logic req_ready;
      logic accept;
      logic clr_step;
      logic dir_go;
      logic early_done;
      logic tab_done;
   } ctrl_cmd_type;

   typedef struct packed {
      logic req_valid;
      logic clr_last;
      logic early_finish;
      logic out_free;
   } dp_status_type;

endpackage

// ===== rtl/ptu_ifs.sv =====
// Request and response channel interfaces of the page table unit.
interface ptu_req_if;
   import ptu_pkg::*;
   logic                valid;
   logic                ready;
   logic [CMD_W-1:0]    command;
   logic [VA_W-1:0]     virt_addr;
   logic [FRAME_W-1:0]  frame_number;

   modport source(output valid, output command, output virt_addr, output frame_number,
                  input ready);
   modport sink(input valid, input command, input virt_addr, input frame_number,
                output ready);
endinterface

interface ptu_rsp_if;
   import ptu_pkg::*;
   logic                valid;
   logic                ready;
   logic [PA_W-1:0]     phys_addr;
   logic [STATUS_W-1:0] status;
   logic                large_page;

   modport source(output valid, output phys_addr, output status, output large_page,
                  input ready);
   modport sink(input valid, input phys_addr, input status, input large_page,
                output ready);
endinterface

// ===== rtl/ptu_ctrl.sv =====
// Sequencer of the page table unit: clear sweep, directory step, table step.
module ptu_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  ptu_pkg::dp_status_type status,
   output ptu_pkg::ctrl_cmd_type  cmd
);
   import ptu_pkg::*;

   state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      unique case (state_ff)
         ST_CLEAR: begin
            cmd.clr_step = 1'b1;
            if (status.clr_last) state_in = ST_IDLE;
         end
         ST_IDLE: begin
            cmd.req_ready = 1'b1;
            cmd.accept    = status.req_valid;
            if (status.req_valid) state_in = ST_DIR;
         end
         ST_DIR: begin
            if (status.early_finish) begin
               // hold until the output register can take the beat
               if (status.out_free) begin
                  cmd.early_done = 1'b1;
                  state_in       = ST_IDLE;
               end
            end else begin
               cmd.dir_go = 1'b1;
               state_in   = ST_TAB;
            end
         end
         ST_TAB: begin
            if (status.out_free) begin
               cmd.tab_done = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_CLEAR;
      endcase
   end

   ctrl_tab_exit_a: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_TAB |=> state_ff == ST_IDLE || state_ff == ST_TAB)
      else $error("table step left to an unexpected state");

endmodule

// ===== rtl/ptu_dpath.sv =====
// Directory and table memories, request registers, decisions and output register.
module ptu_dpath #(
   parameter int TABLE_SLOTS          = 16,
   parameter int KERNEL_LARGE_ENTRIES = 32
) (
   input  logic                   clock,
   input  logic                   reset,
   input  ptu_pkg::ctrl_cmd_type  cmd,
   output ptu_pkg::dp_status_type status,
   ptu_req_if.sink                req_if,
   ptu_rsp_if.source              rsp_if
);
   import ptu_pkg::*;

   localparam int SLOT_W      = (TABLE_SLOTS > 1) ? $clog2(TABLE_SLOTS) : 1;
   localparam int NF_W        = $clog2(TABLE_SLOTS + 1);
   localparam int TABLE_DEPTH = TABLE_SLOTS * PAGES_PER_TABLE;
   localparam int TAB_AW      = $clog2(TABLE_DEPTH);
   localparam int DIR_W       = SLOT_W + 2;

   logic [DIR_W-1:0]    dir_mem [DIR_ENTRIES];
   logic [TE_W-1:0]     tab_mem [TABLE_DEPTH];

   logic [CMD_W-1:0]    cmd_ff;
   logic [VA_W-1:0]     va_ff;
   logic [FRAME_W-1:0]  frame_ff;
   logic [DIR_W-1:0]    dir_rd_ff;
   logic [TE_W-1:0]     tab_rd_ff;
   logic [TAB_AW-1:0]   tab_addr_ff;
   logic [NF_W-1:0]     next_free_ff;
   logic [TAB_AW-1:0]   clr_cnt_ff;
   logic                rsp_valid_ff;
   logic [PA_W-1:0]     phys_ff;
   logic [STATUS_W-1:0] status_ff;
   logic                large_ff;

   logic                d_present, d_large;
   logic [SLOT_W-1:0]   d_slot;
   logic                slot_avail;
   logic                early_finish, alloc;
   logic [PA_W-1:0]     early_phys;
   logic [STATUS_W-1:0] early_status;
   logic                early_large;

   logic                t_present;
   logic                tab_wr_req;
   logic [TE_W-1:0]     tab_wr_val;
   logic [PA_W-1:0]     tab_phys;
   logic [STATUS_W-1:0] tab_status;

   logic [SLOT_W-1:0]   slot_sel;
   logic [TAB_AW-1:0]   tab_raddr;
   logic                clr_in_dir, clr_kernel;
   logic                dir_we;
   logic [DIR_AW-1:0]   dir_waddr;
   logic [DIR_W-1:0]    dir_wdata;
   logic                tab_we;
   logic [TAB_AW-1:0]   tab_waddr;
   logic [TE_W-1:0]     tab_wdata;

   assign req_if.ready = cmd.req_ready;

   assign d_present  = dir_rd_ff[DIR_W-1];
   assign d_large    = dir_rd_ff[DIR_W-2];
   assign d_slot     = dir_rd_ff[SLOT_W-1:0];
   assign slot_avail = next_free_ff < NF_W'(TABLE_SLOTS);

   // directory step: decide whether the table is needed at all
   always_comb begin
      early_finish = 1'b0;
      alloc        = 1'b0;
      early_phys   = '0;
      early_status = STATUS_OK;
      early_large  = 1'b0;
      case (cmd_ff)
         CMD_TRANSLATE: begin
            if (!d_present) begin
               early_finish = 1'b1;
               early_status = STATUS_ABSENT;
            end else if (d_large) begin
               // identity map: directory index joined with the low bits is the address
               early_finish = 1'b1;
               early_phys   = va_ff;
               early_large  = 1'b1;
            end
         end
         CMD_MAP: begin
            if (d_present && d_large) begin
               early_finish = 1'b1;
               early_status = STATUS_LARGE;
            end else if (!d_present && !slot_avail) begin
               early_finish = 1'b1;
               early_status = STATUS_NO_SLOT;
            end else begin
               alloc = !d_present;
            end
         end
         CMD_UNMAP: begin
            if (!d_present) begin
               early_finish = 1'b1;
               early_status = STATUS_ABSENT;
            end else if (d_large) begin
               early_finish = 1'b1;
               early_status = STATUS_LARGE;
            end
         end
         default: early_finish = 1'b1;
      endcase
   end

   // table step
   assign t_present = tab_rd_ff[TE_W-1];

   always_comb begin
      tab_wr_req = 1'b0;
      tab_wr_val = '0;
      tab_phys   = '0;
      tab_status = STATUS_OK;
      case (cmd_ff)
         CMD_TRANSLATE: begin
            if (t_present) tab_phys = {tab_rd_ff[FRAME_W-1:0], va_ff[OFFSET_W-1:0]};
            else           tab_status = STATUS_ABSENT;
         end
         CMD_MAP: begin
            if (t_present) begin
               tab_status = STATUS_MAPPED;
            end else begin
               tab_wr_req = 1'b1;
               tab_wr_val = {1'b1, frame_ff};
            end
         end
         CMD_UNMAP: begin
            if (t_present) tab_wr_req = 1'b1;
            else           tab_status = STATUS_ABSENT;
         end
         default: tab_wr_req = 1'b0;
      endcase
   end

   assign slot_sel  = alloc ? SLOT_W'(next_free_ff) : d_slot;
   assign tab_raddr = TAB_AW'({slot_sel, va_ff[OFFSET_W +: PAGE_W]});

   assign clr_in_dir = (clr_cnt_ff >> DIR_AW) == TAB_AW'(0);
   assign clr_kernel = {1'b0, clr_cnt_ff[DIR_AW-1:0]} < DIR_CW'(KERNEL_LARGE_ENTRIES);

   assign dir_we    = (cmd.clr_step && clr_in_dir) || (cmd.dir_go && alloc);
   assign dir_waddr = cmd.clr_step ? clr_cnt_ff[DIR_AW-1:0] : va_ff[VA_W-1 -: DIR_AW];
   assign dir_wdata = cmd.clr_step ? {clr_kernel, clr_kernel, {SLOT_W{1'b0}}}
                                   : {1'b1, 1'b0, SLOT_W'(next_free_ff)};

   assign tab_we    = cmd.clr_step || (cmd.tab_done && tab_wr_req);
   assign tab_waddr = cmd.clr_step ? clr_cnt_ff : tab_addr_ff;
   assign tab_wdata = cmd.clr_step ? '0 : tab_wr_val;

   always_ff @(posedge clock) begin
      if (dir_we) dir_mem[dir_waddr] <= dir_wdata;
      if (cmd.accept) dir_rd_ff <= dir_mem[req_if.virt_addr[VA_W-1 -: DIR_AW]];
   end

   always_ff @(posedge clock) begin
      if (tab_we) tab_mem[tab_waddr] <= tab_wdata;
      if (cmd.dir_go) tab_rd_ff <= tab_mem[tab_raddr];
   end

   always_ff @(posedge clock) begin
      if (cmd.accept) begin
         cmd_ff   <= req_if.command;
         va_ff    <= req_if.virt_addr;
         frame_ff <= req_if.frame_number;
      end
      if (cmd.dir_go) tab_addr_ff <= tab_raddr;
      if (cmd.early_done) begin
         phys_ff   <= early_phys;
         status_ff <= early_status;
         large_ff  <= early_large;
      end else if (cmd.tab_done) begin
         phys_ff   <= tab_phys;
         status_ff <= tab_status;
         large_ff  <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         next_free_ff <= '0;
         clr_cnt_ff   <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (cmd.dir_go && alloc) next_free_ff <= next_free_ff + NF_W'(1);
         if (cmd.clr_step)        clr_cnt_ff   <= clr_cnt_ff + TAB_AW'(1);
         if (cmd.early_done || cmd.tab_done) rsp_valid_ff <= 1'b1;
         else if (rsp_if.ready)              rsp_valid_ff <= 1'b0;
      end
   end

   assign status.req_valid    = req_if.valid;
   assign status.clr_last     = clr_cnt_ff == TAB_AW'(TABLE_DEPTH - 1);
   assign status.early_finish = early_finish;
   assign status.out_free     = !rsp_valid_ff || rsp_if.ready;

   assign rsp_if.valid      = rsp_valid_ff;
   assign rsp_if.phys_addr  = phys_ff;
   assign rsp_if.status     = status_ff;
   assign rsp_if.large_page = large_ff;

   dp_slot_bound_a: assert property (@(posedge clock) disable iff (reset)
      next_free_ff <= NF_W'(TABLE_SLOTS))
      else $error("slot pool count ran past the pool size");

   dp_alloc_map_a: assert property (@(posedge clock) disable iff (reset)
      cmd.dir_go && alloc |-> cmd_ff == CMD_MAP && slot_avail)
      else $error("table slot taken outside a map with a free slot");

   dp_rsp_source_a: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(cmd.early_done || cmd.tab_done))
      else $error("response beat raised without a finished request");

   dp_no_overwrite_a: assert property (@(posedge clock) disable iff (reset)
      (cmd.early_done || cmd.tab_done) |-> !rsp_valid_ff || rsp_if.ready)
      else $error("result loaded over a beat still waiting");

endmodule

// ===== rtl/two_level_page_table_unit_core.sv =====
// Top level of the two-level page table unit: sequencer plus datapath.
// Each request passes from acceptance to its response beat through the directory
// memory read, the dependent table memory read, and the result with any table
// write-back; commands that the directory entry settles (large pages, absent
// entries, full pool) skip the table read. A new request is accepted once the
// unit is back in its idle state, while an earlier response may still be
// waiting; a result that finds the response register still full holds the unit
// until that beat leaves. After reset the unit sweeps its memories, one entry
// per cycle, over all TABLE_SLOTS*1024 table entries, restoring the identity-
// mapped large entries below KERNEL_LARGE_ENTRIES; req_if.ready stays low for
// that time.
module two_level_page_table_unit_core #(
   parameter int TABLE_SLOTS          = 16,
   parameter int KERNEL_LARGE_ENTRIES = 32
) (
   input logic       clock,
   input logic       reset,
   ptu_req_if.sink   req_if,
   ptu_rsp_if.source rsp_if
);
   import ptu_pkg::*;

   ctrl_cmd_type  cmd;
   dp_status_type status;

   ptu_ctrl u_ctrl (
      .clock  (clock),
      .reset  (reset),
      .status (status),
      .cmd    (cmd)
   );

   ptu_dpath #(
      .TABLE_SLOTS          (TABLE_SLOTS),
      .KERNEL_LARGE_ENTRIES (KERNEL_LARGE_ENTRIES)
   ) u_dpath (
      .clock  (clock),
      .reset  (reset),
      .cmd    (cmd),
      .status (status),
      .req_if (req_if),
      .rsp_if (rsp_if)
   );

endmodule

// ===== verif/ptu_walk_checker.sv =====
// Page walk predictor and response scoreboard for the page table unit.
module ptu_walk_checker #(
   parameter int TABLE_SLOTS          = 16,
   parameter int KERNEL_LARGE_ENTRIES = 32
) (
   input  logic clock,
   input  logic reset,
   ptu_req_if   req_if,
   ptu_rsp_if   rsp_if,
   output int   mismatches,
   output int   outstanding
);
   import ptu_pkg::*;

   typedef struct {
      logic [PA_W-1:0]     phys_addr;
      logic [STATUS_W-1:0] status;
      logic                large_page;
   } walk_result_type;

   bit                dir_present[DIR_ENTRIES];
   bit                dir_large[DIR_ENTRIES];
   int                dir_slot[DIR_ENTRIES];
   logic [TE_W-1:0]   page_entry[TABLE_SLOTS*PAGES_PER_TABLE];
   int                slots_used;
   walk_result_type   pending_walks[$];

   function automatic void clear_tables();
      for (int d = 0; d < DIR_ENTRIES; d++) begin
         dir_present[d] = (d < KERNEL_LARGE_ENTRIES);
         dir_large[d]   = (d < KERNEL_LARGE_ENTRIES);
         dir_slot[d]    = 0;
      end
      for (int e = 0; e < TABLE_SLOTS*PAGES_PER_TABLE; e++)
         page_entry[e] = '0;
      slots_used = 0;
   endfunction

   // Walk the directory and table for one command, updating the shadow state.
   function automatic walk_result_type walk_page(logic [CMD_W-1:0] command,
                                                 logic [VA_W-1:0] virt_addr,
                                                 logic [FRAME_W-1:0] frame_number);
      walk_result_type   res;
      logic [DIR_AW-1:0] dir;
      logic [PAGE_W-1:0] page;
      int                idx;
      res.phys_addr  = '0;
      res.status     = STATUS_OK;
      res.large_page = 1'b0;
      dir  = virt_addr[VA_W-1 -: DIR_AW];
      page = virt_addr[OFFSET_W +: PAGE_W];
      case (command)
         CMD_TRANSLATE: begin
            if (!dir_present[dir]) begin
               res.status = STATUS_ABSENT;
            end else if (dir_large[dir]) begin
               res.phys_addr  = {dir, virt_addr[VA_W-DIR_AW-1:0]};
               res.large_page = 1'b1;
            end else begin
               idx = dir_slot[dir] * PAGES_PER_TABLE + page;
               if (!page_entry[idx][FRAME_W])
                  res.status = STATUS_ABSENT;
               else
                  res.phys_addr = {page_entry[idx][FRAME_W-1:0], virt_addr[OFFSET_W-1:0]};
            end
         end
         CMD_MAP: begin
            if (dir_present[dir] && dir_large[dir]) begin
               res.status = STATUS_LARGE;
            end else if (!dir_present[dir] && slots_used >= TABLE_SLOTS) begin
               res.status = STATUS_NO_SLOT;
            end else begin
               if (!dir_present[dir]) begin
                  dir_present[dir] = 1'b1;
                  dir_large[dir]   = 1'b0;
                  dir_slot[dir]    = slots_used;
                  slots_used++;
               end
               idx = dir_slot[dir] * PAGES_PER_TABLE + page;
               if (page_entry[idx][FRAME_W])
                  res.status = STATUS_MAPPED;
               else
                  page_entry[idx] = {1'b1, frame_number};
            end
         end
         CMD_UNMAP: begin
            if (!dir_present[dir]) begin
               res.status = STATUS_ABSENT;
            end else if (dir_large[dir]) begin
               res.status = STATUS_LARGE;
            end else begin
               idx = dir_slot[dir] * PAGES_PER_TABLE + page;
               if (!page_entry[idx][FRAME_W])
                  res.status = STATUS_ABSENT;
               else
                  page_entry[idx] = '0;
            end
         end
         default: ;
      endcase
      return res;
   endfunction

   initial begin
      mismatches  = 0;
      outstanding = 0;
   end

   always @(posedge clock) begin
      walk_result_type want;
      walk_result_type next_walk;
      if (reset) begin
         clear_tables();
         pending_walks.delete();
      end else begin
         if (req_if.valid && req_if.ready) begin
            next_walk = walk_page(req_if.command, req_if.virt_addr, req_if.frame_number);
            pending_walks.insert(pending_walks.size(), next_walk);
         end
         if (rsp_if.valid && rsp_if.ready) begin
            if (pending_walks.size() == 0) begin
               $error("response beat with no request outstanding");
               mismatches++;
            end else begin
               want = pending_walks.pop_front();
               if (rsp_if.phys_addr !== want.phys_addr) begin
                  $error("phys_addr: expected %h, got %h", want.phys_addr, rsp_if.phys_addr);
                  mismatches++;
               end
               if (rsp_if.status !== want.status) begin
                  $error("status: expected %0d, got %0d", want.status, rsp_if.status);
                  mismatches++;
               end
               if (rsp_if.large_page !== want.large_page) begin
                  $error("large_page: expected %b, got %b", want.large_page,
                         rsp_if.large_page);
                  mismatches++;
               end
            end
         end
      end
      outstanding = pending_walks.size();
   end

endmodule

// ===== verif/two_level_page_table_unit_core_test.sv =====
// Stimulus and verdict for the two-level page table unit.
module two_level_page_table_unit_core_test;
   import ptu_pkg::*;

   localparam int TABLE_SLOTS     = 16;
   localparam int KERNEL_LARGE    = 32;
   localparam int ITEMS_PER_PHASE = 450;

   logic clock;
   logic reset;
   int   req_idle_pct;
   int   rsp_idle_pct;
   int   mismatches;
   int   outstanding;

   ptu_req_if req_if();
   ptu_rsp_if rsp_if();

   two_level_page_table_unit_core #(
      .TABLE_SLOTS          (TABLE_SLOTS),
      .KERNEL_LARGE_ENTRIES (KERNEL_LARGE)
   ) dut (
      .clock  (clock),
      .reset  (reset),
      .req_if (req_if),
      .rsp_if (rsp_if)
   );

   ptu_walk_checker #(
      .TABLE_SLOTS          (TABLE_SLOTS),
      .KERNEL_LARGE_ENTRIES (KERNEL_LARGE)
   ) walk_check (
      .clock       (clock),
      .reset       (reset),
      .req_if      (req_if),
      .rsp_if      (rsp_if),
      .mismatches  (mismatches),
      .outstanding (outstanding)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   initial begin
      rsp_if.ready = 1'b0;
   end

   always @(posedge clock) begin
      rsp_if.ready <= ($urandom_range(0, 99) >= rsp_idle_pct);
   end

   initial begin
      #3_000_000;
      $display("[FAIL] regression broken");
      $finish;
   end

   // Present one request beat, after a random gap, and hold until accepted.
   task automatic issue(logic [CMD_W-1:0] command, logic [VA_W-1:0] virt_addr,
                        logic [FRAME_W-1:0] frame_number);
      int gap;
      gap = 0;
      while (gap < 12 && $urandom_range(0, 99) < req_idle_pct)
         gap++;
      if (gap > 0) begin
         req_if.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_if.valid        <= 1'b1;
      req_if.command      <= command;
      req_if.virt_addr    <= virt_addr;
      req_if.frame_number <= frame_number;
      @(posedge clock);
      while (!req_if.ready) @(posedge clock);
   endtask

   // Hold the request side until every outstanding walk has answered.
   task automatic drain();
      req_if.valid <= 1'b0;
      @(posedge clock);
      while (outstanding != 0) @(posedge clock);
   endtask

   // Mostly a small working set of directories and pages, so that map, unmap
   // and translate hit the same entries; the rest spans the whole space.
   function automatic logic [VA_W-1:0] pick_addr();
      logic [DIR_AW-1:0] dir;
      logic [PAGE_W-1:0] page;
      int                roll;
      roll = $urandom_range(0, 99);
      if (roll < 20)
         dir = DIR_AW'($urandom_range(0, KERNEL_LARGE - 1));
      else if (roll < 80)
         dir = DIR_AW'(KERNEL_LARGE + $urandom_range(0, 11) * 61);
      else if (roll < 90)
         dir = '1;
      else
         dir = DIR_AW'($urandom);
      if ($urandom_range(0, 99) < 70)
         page = PAGE_W'($urandom_range(0, 7));
      else
         page = PAGE_W'($urandom);
      return {dir, page, OFFSET_W'($urandom)};
   endfunction

   function automatic logic [CMD_W-1:0] pick_command();
      int roll;
      roll = $urandom_range(0, 99);
      if (roll < 35)
         return CMD_MAP;
      else if (roll < 75)
         return CMD_TRANSLATE;
      else
         return CMD_UNMAP;
   endfunction

   initial begin
      reset               = 1'b1;
      req_if.valid        = 1'b0;
      req_if.command      = CMD_TRANSLATE;
      req_if.virt_addr    = '0;
      req_if.frame_number = '0;
      req_idle_pct        = 25;
      rsp_idle_pct        = 54;
      repeat (8) @(posedge clock);
      reset <= 1'b0;

      // large pages at both ends of the kernel window, then an absent directory
      issue(CMD_TRANSLATE, 32'h0000_0000, 20'h0_0000);
      issue(CMD_TRANSLATE, 32'h07FF_FFFF, 20'h0_0000);
      issue(CMD_TRANSLATE, 32'h0800_0000, 20'h0_0000);
      issue(CMD_MAP,       32'h0140_0000, 20'h1_2345);
      issue(CMD_UNMAP,     32'h07C0_0000, 20'h0_0000);
      issue(CMD_UNMAP,     32'h0800_0000, 20'h0_0000);
      issue(CMD_MAP,       32'h0000_0000, 20'hF_FFFF);
      // new table at the top directory, double map, absent page in a live table
      issue(CMD_MAP,       32'hFFFF_FFFF, 20'hF_FFFF);
      issue(CMD_TRANSLATE, 32'hFFFF_FFFF, 20'h0_0000);
      issue(CMD_MAP,       32'hFFFF_F000, 20'h0_0000);
      issue(CMD_TRANSLATE, 32'hFFC0_0123, 20'h0_0000);
      issue(CMD_UNMAP,     32'hFFC0_0000, 20'h0_0000);
      issue(CMD_UNMAP,     32'hFFFF_F800, 20'h0_0000);
      issue(CMD_TRANSLATE, 32'hFFFF_FABC, 20'h0_0000);
      issue(CMD_MAP,       32'h0800_0ABC, 20'h0_0000);
      issue(CMD_TRANSLATE, 32'h0800_0FFF, 20'h0_0000);
      issue(CMD_MAP,       32'hFFFF_F000, 20'hA_AAAA);
      issue(CMD_TRANSLATE, 32'hFFFF_F555, 20'h0_0000);
      drain();

      for (int phase = 0; phase < 3; phase++) begin
         case (phase)
            0: begin req_idle_pct = 25; rsp_idle_pct = 54; end
            1: begin req_idle_pct = 54; rsp_idle_pct = 25; end
            default: begin req_idle_pct = 0; rsp_idle_pct = 0; end
         endcase
         for (int n = 0; n < ITEMS_PER_PHASE; n++)
            issue(pick_command(), pick_addr(), FRAME_W'($urandom));
         if (phase < 2)
            drain();
      end

      req_if.valid <= 1'b0;
      while (outstanding != 0) @(posedge clock);
      repeat (10) @(posedge clock);
      if (mismatches == 0 && outstanding == 0)
         $display("[ OK ] regression clean");
      else
         $display("[FAIL] regression broken");
      $finish;
   end

endmodule

// ===== filelist.f =====
rtl/ptu_pkg.sv
rtl/ptu_ifs.sv
rtl/ptu_ctrl.sv
rtl/ptu_dpath.sv
rtl/two_level_page_table_unit_core.sv
verif/ptu_walk_checker.sv
verif/two_level_page_table_unit_core_test.sv
